### hw/rtl/assert_macros.svh
// Assertion helpers used by the lookup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/crrl_pkg.sv
`default_nettype none

package crrl_pkg;

	localparam int TBL_DEPTH = 1024;
	localparam int IDX_W     = 10;
	localparam int RNG_W     = 11;
	localparam int WORD_W    = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [RNG_W-1:0] TBL_LIMIT = RNG_W'(TBL_DEPTH);

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_LOOKUP = 2'd1;
	localparam logic [1:0] ACT_NULLS  = 2'd2;

	localparam logic [1:0] STS_OK         = 2'd0;
	localparam logic [1:0] STS_NO_ROW     = 2'd1;
	localparam logic [1:0] STS_BAD_OFFSET = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STREAM_SIZE = 2'd2;

	typedef struct packed {
		logic [1:0]        action;
		logic [IDX_W-1:0]  entry_index;
		logic [WORD_W-1:0] end_row;
		logic [WORD_W-1:0] chunk_offset;
		logic [WORD_W-1:0] nulls_in_chunk;
		logic [WORD_W-1:0] row_id;
	} crrl_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [IDX_W-1:0]  found_index;
		logic [WORD_W-1:0] found_offset;
		logic [WORD_W-1:0] found_length;
		logic [WORD_W-1:0] first_row;
		logic [WORD_W-1:0] null_count;
	} crrl_res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_FETCH_A,
		S_FETCH_B,
		S_CHECK,
		S_NULL
	} crrl_state_t;

	// Midpoint of a non-empty window [lo, hi).
	function automatic logic [RNG_W-1:0] mid_of(input logic [RNG_W-1:0] lo,
			input logic [RNG_W-1:0] hi);
		logic [RNG_W-1:0] diff;
		diff = hi - lo;
		return lo + (diff >> 1);
	endfunction

endpackage

`default_nettype wire

### hw/rtl/crrl_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module crrl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/chunk_row_range_lookup.sv
`default_nettype none

// Channel     Direction  Handshake                 Payload
// ---------   ---------  ------------------------  ---------------------------------
// request     in         start & !busy             req    (crrl_req_t)
// result      out        done, one cycle, no stall result (crrl_res_t)
// config      in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// A load writes the tables when accepted; a null-count read goes through the null RAM read
// and S_NULL before its result shows. A lookup runs one probe per cycle against the end-row
// RAM (at most 11 probes for 1024 entries), then S_FETCH_A and S_FETCH_B fetch the neighbor
// rows and offsets and S_CHECK forms the result. An empty range answers at once.
// Reset clears the configuration and the controller; table contents are not reset.
// The receiver cannot stall: done marks each result for exactly one cycle.
module chunk_row_range_lookup (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  crrl_pkg::crrl_req_t                 req,
	output logic                                done,
	output crrl_pkg::crrl_res_t                 result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [crrl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [crrl_pkg::WORD_W-1:0]         cfg_data
);
	import crrl_pkg::*;

	`include "assert_macros.svh"

	// Controller state and configuration registers.
	crrl_state_t       state_q, state_d;
	logic [RNG_W-1:0]  range_start_q, range_end_q;
	logic [WORD_W-1:0] stream_size_q;
	logic              done_q;

	// Search window. lo_q ends up as the index of the found chunk.
	logic [RNG_W-1:0]  lo_q, hi_q, stop_q;
	logic [IDX_W-1:0]  mid_q;
	logic [WORD_W-1:0] row_q, off_q, first_q;
	crrl_res_t         res_q, res_d;
	logic              res_ld;

	// RAM ports.
	logic              tbl_we;
	logic              re_ren, off_ren, nul_ren;
	logic [IDX_W-1:0]  re_raddr, off_raddr, nul_raddr;
	logic [WORD_W-1:0] re_rdata, off_rdata, nul_rdata;

	logic              accept;
	logic [RNG_W-1:0]  stop_now, mid_start;
	logic              empty_rng;
	logic              go_right, search_more;
	logic [RNG_W-1:0]  nlo, nhi, nmid;
	logic              idx_last, at_stop, bad_off;
	logic [WORD_W-1:0] next_off;
	logic              probe_ok;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

	// The searched range is clipped to the table; an empty or inverted range misses.
	assign stop_now  = (range_end_q > TBL_LIMIT) ? TBL_LIMIT : range_end_q;
	assign empty_rng = (range_start_q >= stop_now);
	assign mid_start = mid_of(range_start_q, stop_now);

	// One upper-bound step: the probed end row is compared against the row id, the
	// window shrinks, and the next probe address goes straight back to the RAM.
	assign go_right    = (re_rdata <= row_q);
	assign nlo         = go_right ? ({1'b0, mid_q} + RNG_W'(1)) : lo_q;
	assign nhi         = go_right ? hi_q : {1'b0, mid_q};
	assign search_more = (nlo < nhi);
	assign nmid        = mid_of(nlo, nhi);

	// After the search, lo_q is the candidate chunk. Landing on the range end means the
	// row lies beyond the last chunk. The last chunk ends at the stream size.
	assign at_stop  = (lo_q == stop_q);
	assign idx_last = ((lo_q + RNG_W'(1)) >= stop_q);
	assign next_off = idx_last ? stream_size_q : off_rdata;
	assign bad_off  = (off_q > next_off) || (next_off > stream_size_q);

	// Loads write all three tables at once. The entry index field spans the whole
	// table, so every load index is in range.
	assign tbl_we = accept && (req.action == ACT_LOAD);

	crrl_ram #(.WIDTH(WORD_W), .DEPTH(TBL_DEPTH)) u_row_end_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (req.entry_index),
		.wdata (req.end_row),
		.re    (re_ren),
		.raddr (re_raddr),
		.rdata (re_rdata)
	);

	crrl_ram #(.WIDTH(WORD_W), .DEPTH(TBL_DEPTH)) u_offset_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (req.entry_index),
		.wdata (req.chunk_offset),
		.re    (off_ren),
		.raddr (off_raddr),
		.rdata (off_rdata)
	);

	crrl_ram #(.WIDTH(WORD_W), .DEPTH(TBL_DEPTH)) u_null_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (req.entry_index),
		.wdata (req.nulls_in_chunk),
		.re    (nul_ren),
		.raddr (nul_raddr),
		.rdata (nul_rdata)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (req.action == ACT_LOOKUP) && !empty_rng) begin
					state_d = S_SEARCH;
				end else if (accept && (req.action == ACT_NULLS)) begin
					state_d = S_NULL;
				end
			end
			S_SEARCH: begin
				state_d = search_more ? S_SEARCH : S_FETCH_A;
			end
			S_FETCH_A: begin
				state_d = at_stop ? S_IDLE : S_FETCH_B;
			end
			S_FETCH_B: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = S_IDLE;
			end
			S_NULL: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// RAM read control and result formation.
	always_comb begin
		re_ren    = 1'b0;
		re_raddr  = mid_start[IDX_W-1:0];
		off_ren   = 1'b0;
		off_raddr = lo_q[IDX_W-1:0];
		nul_ren   = 1'b0;
		nul_raddr = req.entry_index;
		res_ld    = 1'b0;
		res_d     = '0;
		case (state_q)
			S_IDLE: begin
				re_ren  = accept && (req.action == ACT_LOOKUP) && !empty_rng;
				nul_ren = accept && (req.action == ACT_NULLS);
				if (accept && (req.action == ACT_LOOKUP) && empty_rng) begin
					res_ld       = 1'b1;
					res_d.status = STS_NO_ROW;
				end
			end
			S_SEARCH: begin
				re_ren   = search_more;
				re_raddr = nmid[IDX_W-1:0];
			end
			S_FETCH_A: begin
				// First row comes from the previous entry's end row.
				re_ren    = !at_stop;
				re_raddr  = lo_q[IDX_W-1:0] - IDX_W'(1);
				off_ren   = !at_stop;
				off_raddr = lo_q[IDX_W-1:0];
				if (at_stop) begin
					res_ld       = 1'b1;
					res_d.status = STS_NO_ROW;
				end
			end
			S_FETCH_B: begin
				off_ren   = 1'b1;
				off_raddr = lo_q[IDX_W-1:0] + IDX_W'(1);
			end
			S_CHECK: begin
				res_ld = 1'b1;
				if (bad_off) begin
					res_d.status = STS_BAD_OFFSET;
				end else begin
					res_d.status       = STS_OK;
					res_d.found_index  = lo_q[IDX_W-1:0];
					res_d.found_offset = off_q;
					res_d.found_length = next_off - off_q;
					res_d.first_row    = first_q;
				end
			end
			S_NULL: begin
				res_ld           = 1'b1;
				res_d.status     = STS_OK;
				res_d.null_count = nul_rdata;
			end
			default: begin
				res_ld = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			done_q        <= 1'b0;
			range_start_q <= '0;
			range_end_q   <= '0;
			stream_size_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= res_ld;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RANGE_START: range_start_q <= cfg_data[RNG_W-1:0];
					CFG_RANGE_END:   range_end_q   <= cfg_data[RNG_W-1:0];
					CFG_STREAM_SIZE: stream_size_q <= cfg_data;
					default:         stream_size_q <= stream_size_q;
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_q <= res_d;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					lo_q   <= range_start_q;
					hi_q   <= stop_now;
					stop_q <= stop_now;
					mid_q  <= mid_start[IDX_W-1:0];
					row_q  <= req.row_id;
				end
			end
			S_SEARCH: begin
				lo_q  <= nlo;
				hi_q  <= nhi;
				mid_q <= nmid[IDX_W-1:0];
			end
			S_FETCH_B: begin
				off_q   <= off_rdata;
				first_q <= (lo_q == range_start_q) ? '0 : re_rdata;
			end
			default: begin
				off_q <= off_q;
			end
		endcase
	end

	// A probe always lies inside the live window, and the window inside the range.
	assign probe_ok = (lo_q < hi_q) && (hi_q <= stop_q) &&
		({1'b0, mid_q} >= lo_q) && ({1'b0, mid_q} < hi_q);
	`ASSERT_IMPL(a_search_window, clk, arst_n, state_q == S_SEARCH, probe_ok)
	// No result appears without a request in flight or just accepted.
	`ASSERT_NEXT(a_no_phantom, clk, arst_n, (state_q == S_IDLE) && !accept, !done_q)
	// A load never produces a result.
	`ASSERT_NEXT(a_load_silent, clk, arst_n, accept && (req.action == ACT_LOAD), !done_q)

endmodule

`default_nettype wire
